// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(name, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/clbrl_pkg.sv
package clbrl_pkg;

    localparam int WINDOW_FRAMES = 16;
    localparam int IDX_W         = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;

    localparam int BYTES_W = 16;
    localparam int RATE_W  = 20;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 26;
    localparam int TOTAL_W = 20;
    localparam int COUNT_W = 32;

    // The accumulator must hold the full window sum and never be narrower
    // than the reported total, so that saturation can be tested on it.
    localparam int SUM_W = (BYTES_W + IDX_W > TOTAL_W) ? BYTES_W + IDX_W : TOTAL_W;

    localparam int DIV_STEPS = DELAY_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [9:0]         MS_PER_SECOND = 10'd1000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 80;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [0:0] REG_RATE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        KIND_CHECK_DROP    = 2'd0,
        KIND_RECORD_SEND   = 2'd1,
        KIND_ADVANCE_FRAME = 2'd2,
        KIND_PACE_QUERY    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic sum_step;
        logic mul;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  rate_zero;
        logic  sum_last;
        logic  div_last;
        logic  out_busy;
    } status_t;

endpackage

// File: rtl/clbrl_ctrl.sv
`include "assert_macros.svh"

module clbrl_ctrl
    import clbrl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sts.sum_last) begin
                    if (sts.kind == KIND_RECORD_SEND && !sts.rate_zero) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                cmd.finish = !sts.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts_sum, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_SUM, "accepted transfer did not start the window sum")
    `ASSERT_NEXT(a_div_end_finishes, aclk, aresetn, state_reg == ST_DIV && sts.div_last, state_reg == ST_FIN, "division did not hand over to finish")
    `ASSERT_SAME(a_finish_needs_room, aclk, aresetn, cmd.finish, state_reg == ST_FIN && !sts.out_busy, "finish issued while the result register is occupied")
    `ASSERT_NEXT(a_finish_to_idle, aclk, aresetn, cmd.finish, state_reg == ST_IDLE && s_tready, "controller did not return to idle after finish")

endmodule

// File: rtl/clbrl_dp.sv
module clbrl_dp
    import clbrl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                sts,
    input  logic [RATE_W-1:0]      rate_limit,
    input  logic [1:0]             s_tuser,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Latched item.
    kind_t              kind_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic               spawned_reg;
    logic [TIME_W-1:0]  now_reg;

    // Limiter state.
    logic [BYTES_W-1:0] window_reg [WINDOW_FRAMES];
    logic [IDX_W-1:0]   slot_reg;
    logic [COUNT_W-1:0] supp_count_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [DELAY_W-1:0] delay_reg;

    // Window sum and divider.
    logic [SUM_W-1:0]     acc_reg;
    logic [IDX_W-1:0]     sum_idx_reg;
    logic [DELAY_W-1:0]   quo_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic               rate_zero;
    logic [RATE_W:0]    rem_shift;
    logic               rem_ge;
    logic [RATE_W-1:0]  rem_next;
    logic               do_suppress;
    logic               do_store;
    logic [COUNT_W-1:0] supp_count_next;
    logic [DELAY_W-1:0] delay_next;
    logic [TIME_W-1:0]  elapsed;
    logic               may_send;
    logic [TOTAL_W-1:0] total_sat;
    logic [IDX_W-1:0]   slot_inc;

    assign rate_zero = (rate_limit == '0);

    assign rem_shift = {rem_reg, quo_reg[DELAY_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, rate_limit});
    assign rem_next  = rem_ge ? RATE_W'(rem_shift - {1'b0, rate_limit})
                              : rem_shift[RATE_W-1:0];

    assign do_suppress = (kind_reg == KIND_CHECK_DROP) && !rate_zero
                         && (acc_reg > SUM_W'(rate_limit));
    assign do_store    = (kind_reg == KIND_RECORD_SEND) && !rate_zero && spawned_reg;

    assign supp_count_next = do_suppress ? supp_count_reg + 1'b1 : supp_count_reg;
    assign elapsed         = now_reg - last_time_reg;
    assign may_send        = (kind_reg == KIND_PACE_QUERY)
                             && (elapsed >= TIME_W'(delay_reg));
    assign total_sat       = (acc_reg > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : acc_reg[TOTAL_W-1:0];
    assign slot_inc        = (slot_reg == IDX_W'(WINDOW_FRAMES - 1)) ? '0
                                                                      : slot_reg + 1'b1;

    always_comb begin
        delay_next = delay_reg;
        if (kind_reg == KIND_RECORD_SEND) begin
            delay_next = rate_zero ? '0 : quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= kind_t'(s_tuser);
            bytes_reg   <= s_tdata[15:0];
            spawned_reg <= s_tdata[16];
            now_reg     <= s_tdata[48:17];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg     <= '0;
            sum_idx_reg <= '0;
        end else if (cmd.sum_step) begin
            acc_reg     <= acc_reg + SUM_W'(window_reg[sum_idx_reg]);
            sum_idx_reg <= (sum_idx_reg == IDX_W'(WINDOW_FRAMES - 1)) ? '0
                                                                       : sum_idx_reg + 1'b1;
        end
    end

    // Restoring division of bytes*1000 by the rate, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            quo_reg     <= DELAY_W'(bytes_reg) * DELAY_W'(MS_PER_SECOND);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg     <= {quo_reg[DELAY_W-2:0], rem_ge};
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_FRAMES; i++) begin
                window_reg[i] <= '0;
            end
            slot_reg       <= '0;
            supp_count_reg <= '0;
            last_time_reg  <= '0;
            delay_reg      <= '0;
        end else if (cmd.finish) begin
            if (do_suppress) begin
                window_reg[slot_reg] <= '0;
            end else if (do_store) begin
                window_reg[slot_reg] <= bytes_reg;
            end
            if (kind_reg == KIND_ADVANCE_FRAME) begin
                slot_reg <= slot_inc;
            end
            if (kind_reg == KIND_RECORD_SEND) begin
                last_time_reg <= now_reg;
            end
            supp_count_reg <= supp_count_next;
            delay_reg      <= delay_next;
        end
    end

    // The result register lets the next item in while this one waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {supp_count_next, may_send, delay_next, total_sat, do_suppress};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sts.kind      = kind_reg;
    assign sts.rate_zero = rate_zero;
    assign sts.sum_last  = (sum_idx_reg == IDX_W'(WINDOW_FRAMES - 1));
    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_busy  = out_valid_reg && !m_tready;

endmodule

// File: rtl/client_bandwidth_rate_limiter_core.sv
// Each item is summed over the 16 window slots, then a finish step writes the result
// register; record_send with a nonzero rate adds a multiply step and a bit-serial
// divider over the 26 quotient bits in between. A new item is accepted only after
// the finish step, which waits while an unaccepted result occupies the register.
// Reset (aresetn low, synchronous) clears the window, slot index, suppression count,
// last send time, pacing delay, the rate register and any pending result.
module client_bandwidth_rate_limiter_core
    import clbrl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_tuser,  // kind
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // packet_bytes, is_spawned, now_ms, zero pad
    // Results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // suppressed, window_total, send_delay_ms,
                                             // may_send, suppress_total
);

    logic [RATE_W-1:0] rate_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    status_t           sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RATE_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
        end else if (cfg_wr) begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RATE_LIMIT) begin
            prdata = APB_DATA_W'(rate_reg);
        end
    end

    clbrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clbrl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .rate_limit (rate_reg),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import clbrl_pkg::*;

    typedef struct {
        logic               suppressed;
        logic [TOTAL_W-1:0] total;
        logic [DELAY_W-1:0] delay;
        logic               may_send;
        logic [COUNT_W-1:0] drops;
    } limiter_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [1:0]             s_tuser  = '0;  // kind
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;  // packet_bytes, is_spawned, now_ms, zero pad
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // suppressed, window_total, send_delay_ms,
                                            // may_send, suppress_total

    // Shadow state of the limiter.
    logic [BYTES_W-1:0] window_sizes [WINDOW_FRAMES];
    int                 cur_slot;
    logic [COUNT_W-1:0] drop_count;
    logic [TIME_W-1:0]  last_send_ms;
    logic [DELAY_W-1:0] pace_delay;
    logic [RATE_W-1:0]  rate_cfg;

    limiter_result_t    expected_results [$];
    int                 error_count = 0;
    int                 items_sent  = 0;
    int                 burst_left  = 0;
    logic [TIME_W-1:0]  clock_ms;

    client_bandwidth_rate_limiter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void predict_item(input kind_t kind, input logic [BYTES_W-1:0] bytes,
                                         input logic spawned, input logic [TIME_W-1:0] now);
        limiter_result_t    r;
        logic [31:0]        sum;
        logic [31:0]        product;
        logic [TIME_W-1:0]  elapsed;
        int                 i;
        sum = '0;
        for (i = 0; i < WINDOW_FRAMES; i++) begin
            sum = sum + 32'(window_sizes[i]);
        end
        r.suppressed = 1'b0;
        r.may_send   = 1'b0;
        r.total      = (sum > 32'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        case (kind)
            KIND_CHECK_DROP: begin
                if (rate_cfg != '0 && sum > 32'(rate_cfg)) begin
                    r.suppressed           = 1'b1;
                    drop_count             = drop_count + 1'b1;
                    window_sizes[cur_slot] = '0;
                end
            end
            KIND_RECORD_SEND: begin
                last_send_ms = now;
                if (rate_cfg == '0) begin
                    pace_delay = '0;
                end else begin
                    if (spawned) begin
                        window_sizes[cur_slot] = bytes;
                    end
                    product    = 32'(bytes) * 32'd1000;
                    pace_delay = DELAY_W'(product / 32'(rate_cfg));
                end
            end
            KIND_ADVANCE_FRAME: begin
                cur_slot = (cur_slot + 1) % WINDOW_FRAMES;
            end
            default: begin
                elapsed    = now - last_send_ms;
                r.may_send = (elapsed >= 32'(pace_delay));
            end
        endcase
        r.delay = pace_delay;
        r.drops = drop_count;
        expected_results.push_back(r);
    endfunction

    // Holds tvalid across back-to-back transfers within a burst; drops it only for a gap.
    task automatic send_item(input kind_t kind, input logic [BYTES_W-1:0] bytes,
                             input logic spawned, input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, now, spawned, bytes};
        do @(posedge aclk); while (!s_tready);
        predict_item(kind, bytes, spawned, now);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RATE_LIMIT, 2'b00};
        pwdata  <= APB_DATA_W'(rate);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rate_cfg = rate;
        @(posedge aclk);
    endtask

    // Result side: check each transfer, then pick the next ready level from a
    // pattern chosen at random among free flow, random, periodic and long stalls.
    int rx_tick  = 0;
    int rx_mode  = 0;
    int rx_left  = 0;

    always @(posedge aclk) begin : result_side
        limiter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_error($sformatf("result transfer with nothing expected, tdata %h",
                                       m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.suppressed)
                    report_error($sformatf("suppressed: got %0d, expected %0d",
                                           m_tdata[0], want.suppressed));
                if (m_tdata[20:1] !== want.total)
                    report_error($sformatf("window_total: got %0d, expected %0d",
                                           m_tdata[20:1], want.total));
                if (m_tdata[46:21] !== want.delay)
                    report_error($sformatf("send_delay_ms: got %0d, expected %0d",
                                           m_tdata[46:21], want.delay));
                if (m_tdata[47] !== want.may_send)
                    report_error($sformatf("may_send: got %0d, expected %0d",
                                           m_tdata[47], want.may_send));
                if (m_tdata[79:48] !== want.drops)
                    report_error($sformatf("suppress_total: got %0d, expected %0d",
                                           m_tdata[79:48], want.drops));
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= rx_tick[2];
            default: m_tready <= ((rx_tick % 37) > 24);
        endcase
    end

    task automatic test_unlimited_rate();
        send_item(KIND_CHECK_DROP, 16'd0, 1'b0, 32'd0);
        send_item(KIND_RECORD_SEND, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(KIND_PACE_QUERY, 16'd0, 1'b0, 32'hFFFF_FFFF);
        send_item(KIND_CHECK_DROP, 16'hFFFF, 1'b1, 32'd1);
        send_item(KIND_ADVANCE_FRAME, 16'd0, 1'b0, 32'd2);
    endtask

    task automatic test_pacing_extremes();
        drain_results();
        write_rate(20'd1);
        // The largest possible delay, with the elapsed time wrapping past zero.
        send_item(KIND_RECORD_SEND, 16'hFFFF, 1'b1, 32'hFFFF_FFF0);
        send_item(KIND_PACE_QUERY, 16'd0, 1'b0, 32'hFFFF_FFF0 + 32'd65534999);
        send_item(KIND_PACE_QUERY, 16'd0, 1'b0, 32'hFFFF_FFF0 + 32'd65535000);
        send_item(KIND_RECORD_SEND, 16'd0, 1'b1, 32'd5);
        send_item(KIND_PACE_QUERY, 16'd0, 1'b0, 32'd5);
        send_item(KIND_RECORD_SEND, 16'd1, 1'b0, 32'd100);
        send_item(KIND_PACE_QUERY, 16'd0, 1'b1, 32'd1099);
    endtask

    task automatic test_window_drop();
        send_item(KIND_RECORD_SEND, 16'hFFFF, 1'b1, 32'd200);
        send_item(KIND_ADVANCE_FRAME, 16'd0, 1'b0, 32'd201);
        send_item(KIND_RECORD_SEND, 16'd30000, 1'b1, 32'd210);
        send_item(KIND_CHECK_DROP, 16'd0, 1'b0, 32'd220);
        send_item(KIND_CHECK_DROP, 16'd0, 1'b0, 32'd230);
        drain_results();
        write_rate(20'hFFFFF);
        send_item(KIND_RECORD_SEND, 16'hFFFF, 1'b1, 32'd300);
        send_item(KIND_CHECK_DROP, 16'd0, 1'b0, 32'd310);
    endtask

    // Mostly whole frames (check, sends, queries, advance) with random content;
    // the rest is random items and frames that never advance.
    task automatic run_frames(input int count);
        int          target;
        int          n;
        int          j;
        int          offset;
        logic [15:0] bytes;
        logic [31:0] when;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 49) == 0) begin
                drain_results();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_item(kind_t'($urandom_range(0, 3)), 16'($urandom()), 1'($urandom()),
                          $urandom());
            end else begin
                send_item(KIND_CHECK_DROP, 16'($urandom()), 1'($urandom()), clock_ms);
                n = $urandom_range(0, 2);
                for (j = 0; j < n; j++) begin
                    case ($urandom_range(0, 3))
                        0:       bytes = 16'($urandom_range(0, 2000));
                        1:       bytes = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                        default: bytes = 16'($urandom());
                    endcase
                    clock_ms = clock_ms + $urandom_range(0, 20);
                    send_item(KIND_RECORD_SEND, bytes, ($urandom_range(0, 9) != 0), clock_ms);
                end
                n = $urandom_range(0, 2);
                for (j = 0; j < n; j++) begin
                    offset = $urandom_range(0, 4) - 2;
                    case ($urandom_range(0, 2))
                        0:       when = last_send_ms + 32'(pace_delay) + offset;
                        1:       when = clock_ms;
                        default: when = $urandom();
                    endcase
                    send_item(KIND_PACE_QUERY, 16'($urandom()), 1'($urandom()), when);
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(KIND_ADVANCE_FRAME, 16'($urandom()), 1'($urandom()), clock_ms);
                end
                clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(1000, 100000)
                                                                    : $urandom_range(0, 100));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [RATE_W-1:0] phase_rates [8];
        int                p;
        phase_rates[0] = 20'd0;
        phase_rates[1] = 20'd1;
        phase_rates[2] = 20'hFFFFF;
        phase_rates[3] = 20'd1000000;
        phase_rates[4] = 20'($urandom_range(2, 255));
        phase_rates[5] = 20'($urandom_range(1000, 60000));
        phase_rates[6] = 20'($urandom_range(60000, 400000));
        phase_rates[7] = 20'($urandom_range(1, 1048575));
        for (p = 0; p < 8; p++) begin
            drain_results();
            write_rate(phase_rates[p]);
            clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                   : $urandom();
            run_frames(50);
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < WINDOW_FRAMES; i++) begin
            window_sizes[i] = '0;
        end
        cur_slot     = 0;
        drop_count   = '0;
        last_send_ms = '0;
        pace_delay   = '0;
        rate_cfg     = '0;
        clock_ms     = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unlimited_rate();
        test_pacing_extremes();
        test_window_drop();
        test_random_traffic();

        drain_results();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/clbrl_pkg.sv
rtl/clbrl_ctrl.sv
rtl/clbrl_dp.sv
rtl/client_bandwidth_rate_limiter_core.sv
tb/testbench.sv
